@@ hdl/fdbrop_pkg.sv @@
// Shared constants, types and helper functions of the fragment depth and blend raster output.
`default_nettype none
package fdbrop_pkg;

	localparam int PIXELS_DEF     = 65536;
	localparam int DEPTH_BITS_DEF = 24;
	localparam int DEPTH_W        = 24;
	localparam int CNT_W          = 25;
	localparam int PIX_CFG_W      = 17;
	localparam logic [PIX_CFG_W-1:0] PIX_CFG_RESET = 17'd65536;

	localparam logic [1:0] CMD_FRAG  = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [8:0] UNIT_ONE  = 9'd256;
	localparam logic [8:0] HALF_ONE  = 9'd128;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MIX,
		ST_CLEAR,
		ST_DONE
	} rop_state_t;

	typedef logic [3:0][8:0] rgba9_t;

	// Clamps a signed 10-bit component to the range 0 through 256.
	function automatic logic [8:0] unit_clamp(input logic signed [9:0] v);
		logic [8:0] r;
		if (v[9]) begin
			r = 9'd0;
		end else if (v[8:0] > UNIT_ONE) begin
			r = UNIT_ONE;
		end else begin
			r = v[8:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hdl/fdbrop_if.sv @@
// Request, result and configuration channel interfaces.
`default_nettype none
interface fdbrop_req_if import fdbrop_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [15:0]        pixel_index;
	logic [DEPTH_W-1:0] frag_depth;
	logic signed [9:0]  frag_red;
	logic signed [9:0]  frag_green;
	logic signed [9:0]  frag_blue;
	logic signed [9:0]  frag_alpha;
	logic               clear_color_enable;
	logic               clear_depth_enable;
	logic [31:0]        clear_rgba;
	logic [DEPTH_W-1:0] clear_depth_value;

	modport source (
		output valid, command, pixel_index, frag_depth, frag_red, frag_green, frag_blue,
			frag_alpha, clear_color_enable, clear_depth_enable, clear_rgba, clear_depth_value,
		input  ready
	);
	modport sink (
		input  valid, command, pixel_index, frag_depth, frag_red, frag_green, frag_blue,
			frag_alpha, clear_color_enable, clear_depth_enable, clear_rgba, clear_depth_value,
		output ready
	);
endinterface

interface fdbrop_rsp_if import fdbrop_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [31:0]        read_rgba;
	logic [DEPTH_W-1:0] read_depth;
	logic               fragment_passed;

	modport source (output valid, read_rgba, read_depth, fragment_passed, input ready);
	modport sink (input valid, read_rgba, read_depth, fragment_passed, output ready);
endinterface

interface fdbrop_cfg_if import fdbrop_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PIX_CFG_W-1:0] pixels_in_use;

	modport source (output valid, pixels_in_use, input ready);
	modport sink (input valid, pixels_in_use, output ready);
endinterface
`default_nettype wire

@@ hdl/fdbrop_mix.sv @@
// Color blend unit: registered products, then old*(1-a)+new*a truncated to bytes.
`default_nettype none
module fdbrop_mix import fdbrop_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] old_rgba,
	input  wire rgba9_t      color,
	output logic      [31:0] mixed_rgba
);

	logic [3:0][16:0] p_old_s1;
	logic [3:0][16:0] p_new_s1;
	logic [8:0]       inv_a;

	assign inv_a = UNIT_ONE - color[3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				p_old_s1[k] <= 17'(old_rgba[8*k +: 8]) * 17'(inv_a);
				p_new_s1[k] <= 17'(color[k]) * 17'(color[3]);
			end
		end
	end

	always_comb begin
		logic [24:0] sum;
		sum = 25'd0;
		for (int k = 0; k < 4; k++) begin
			sum = {p_old_s1[k], 8'd0} + {p_new_s1[k], 8'd0} - 25'(p_new_s1[k]);
			mixed_rgba[8*k +: 8] = sum[23:16];
		end
	end

endmodule
`default_nettype wire

@@ hdl/fragment_depth_blend_rop_top.sv @@
// Top level of the raster output stage with depth buffer and RGBA8 color buffer.
//
// Channel  Direction  Carries
// req      in         command, pixel, fragment depth and colour, clear fields
// rsp      out        read colour, read depth, pass flag
// cfg      in         pixels_in_use
//
// One request is worked on at a time. A fragment passes from acceptance to the next
// acceptance through memory read, blend products, blend and write back, result hand-off.
// A read skips blend and write back; a clear writes the first min(pixels_in_use, PIXELS) pixels
// in turn through the single write port of each buffer. Reset clears control state only;
// the buffers hold garbage until cleared. A stalled result holds the block in its final state.
`default_nettype none
module fragment_depth_blend_rop_top import fdbrop_pkg::*; #(
	parameter int PIXELS     = PIXELS_DEF,
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fdbrop_req_if.sink   req,
	fdbrop_rsp_if.source rsp,
	fdbrop_cfg_if.sink   cfg
);

	localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int DW = (DEPTH_BITS < DEPTH_W) ? DEPTH_BITS : DEPTH_W;
	localparam logic [CNT_W-1:0] PIX_LIM = CNT_W'(PIXELS);

	logic [31:0] color_mem [PIXELS];
	logic [DW-1:0] depth_mem [PIXELS];

	rop_state_t state_q, state_d;

	logic [PIX_CFG_W-1:0] pixels_in_use_q;
	logic [1:0]           cmd_q;
	logic [AW-1:0]        addr_q;
	logic                 in_range_q;
	logic [DW-1:0]        fd_q;
	rgba9_t               color_q;
	logic                 clr_col_q;
	logic                 clr_dep_q;
	logic [31:0]          clr_rgba_q;
	logic [DW-1:0]        clr_depth_q;
	logic [AW-1:0]        clr_last_q;
	logic [AW-1:0]        cursor_q;
	logic                 pass_s2;

	logic [31:0]   col_rd_q;
	logic [DW-1:0] dep_rd_q;

	logic [31:0]        res_rgba_q;
	logic [DEPTH_W-1:0] res_depth_q;
	logic               res_pass_q;

	logic               rsp_valid_q;
	logic [31:0]        rsp_rgba_q;
	logic [DEPTH_W-1:0] rsp_depth_q;
	logic               rsp_pass_q;

	logic          accept;
	logic          out_free;
	logic          mem_re;
	logic          prod_en;
	logic          out_load;
	logic          col_we;
	logic          dep_we;
	logic [AW-1:0] wr_addr;
	logic [31:0]   col_wd;
	logic [DW-1:0] dep_wd;
	logic [31:0]   mixed_rgba;

	logic [23:0]      px_ext;
	logic [AW-1:0]    in_addr;
	logic             in_range;
	logic [CNT_W-1:0] pix_ext;
	logic [CNT_W-1:0] clr_count;
	logic [CNT_W-1:0] clr_last;
	logic             depth_ok;

	assign px_ext    = 24'(req.pixel_index);
	assign in_addr   = px_ext[AW-1:0];
	assign in_range  = CNT_W'(req.pixel_index) < PIX_LIM;
	assign pix_ext   = CNT_W'(pixels_in_use_q);
	assign clr_count = (pix_ext > PIX_LIM) ? PIX_LIM : pix_ext;
	assign clr_last  = clr_count - CNT_W'(1);
	assign depth_ok  = in_range_q && (dep_rd_q > fd_q);

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_in_use_q <= PIX_CFG_RESET;
		end else if (cfg.valid) begin
			pixels_in_use_q <= cfg.pixels_in_use;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cursor_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				cursor_q <= (cursor_q == clr_last_q) ? '0 : cursor_q + AW'(1);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		mem_re    = 1'b0;
		prod_en   = 1'b0;
		out_load  = 1'b0;
		col_we    = 1'b0;
		dep_we    = 1'b0;
		wr_addr   = addr_q;
		col_wd    = mixed_rgba;
		dep_wd    = fd_q;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				mem_re    = 1'b1;
				if (req.valid) begin
					case (req.command)
						CMD_FRAG:  state_d = ST_READ;
						CMD_READ:  state_d = ST_READ;
						CMD_CLEAR: state_d = (clr_count == '0) ? ST_DONE : ST_CLEAR;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_READ: begin
				prod_en = 1'b1;
				state_d = (cmd_q == CMD_FRAG) ? ST_MIX : ST_DONE;
			end
			ST_MIX: begin
				col_we  = pass_s2;
				dep_we  = pass_s2 && (color_q[3] > HALF_ONE);
				state_d = ST_DONE;
			end
			ST_CLEAR: begin
				wr_addr = cursor_q;
				col_wd  = clr_rgba_q;
				dep_wd  = clr_depth_q;
				col_we  = clr_col_q;
				dep_we  = clr_dep_q;
				if (cursor_q == clr_last_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			color_mem[wr_addr] <= col_wd;
		end
		if (mem_re) begin
			col_rd_q <= color_mem[in_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (dep_we) begin
			depth_mem[wr_addr] <= dep_wd;
		end
		if (mem_re) begin
			dep_rd_q <= depth_mem[in_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= req.command;
			addr_q      <= in_addr;
			in_range_q  <= in_range;
			fd_q        <= req.frag_depth[DW-1:0];
			color_q[0]  <= unit_clamp(req.frag_red);
			color_q[1]  <= unit_clamp(req.frag_green);
			color_q[2]  <= unit_clamp(req.frag_blue);
			color_q[3]  <= unit_clamp(req.frag_alpha);
			clr_col_q   <= req.clear_color_enable;
			clr_dep_q   <= req.clear_depth_enable;
			clr_rgba_q  <= req.clear_rgba;
			clr_depth_q <= req.clear_depth_value[DW-1:0];
			clr_last_q  <= clr_last[AW-1:0];
			res_rgba_q  <= '0;
			res_depth_q <= '0;
			res_pass_q  <= 1'b0;
		end
		if (state_q == ST_READ) begin
			pass_s2 <= (cmd_q == CMD_FRAG) && depth_ok;
			if (cmd_q == CMD_READ && in_range_q) begin
				res_rgba_q  <= col_rd_q;
				res_depth_q <= DEPTH_W'(dep_rd_q);
			end
		end
		if (state_q == ST_MIX) begin
			res_pass_q <= pass_s2;
		end
	end

	fdbrop_mix u_mix (
		.clk        (clk),
		.en         (prod_en),
		.old_rgba   (col_rd_q),
		.color      (color_q),
		.mixed_rgba (mixed_rgba)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_rgba_q  <= res_rgba_q;
			rsp_depth_q <= res_depth_q;
			rsp_pass_q  <= res_pass_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.read_rgba       = rsp_rgba_q;
	assign rsp.read_depth      = rsp_depth_q;
	assign rsp.fragment_passed = rsp_pass_q;

endmodule
`default_nettype wire

@@ hdl/fdbrop_checker.sv @@
// Port-level checks of the raster output stage and their attachment to the top level.
`default_nettype none
module fdbrop_checker import fdbrop_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_ready,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire logic [31:0]        rsp_rgba,
	input wire logic [DEPTH_W-1:0] rsp_depth,
	input wire logic               rsp_pass
);

	logic req_acc;

	assign req_acc = req_valid && req_ready;

	// Only one request is in flight, so the port closes right after an acceptance.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request accepted while another was in flight");

	// A result is not raised straight after its request: the state and result registers lie between them.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !$rose(rsp_valid))
		else $error("result appeared one cycle after its request");

	// A passing fragment never reports read data.
	a_pass_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_pass) |-> (rsp_rgba == 32'd0 && rsp_depth == '0))
		else $error("passing fragment result carries read data");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_rgba) &&
			$stable(rsp_depth) && $stable(rsp_pass)))
		else $error("stalled result changed");

endmodule

bind fragment_depth_blend_rop_top fdbrop_checker u_fdbrop_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_rgba  (rsp.read_rgba),
	.rsp_depth (rsp.read_depth),
	.rsp_pass  (rsp.fragment_passed)
);
`default_nettype wire

@@ sim/fragment_depth_blend_rop_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench that runs the raster output stage against a shadow framebuffer.
module fragment_depth_blend_rop_top_tb;
	import fdbrop_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 300000;
	localparam int PHASES = 8;
	localparam int RANDOM_PER_PHASE = 135;

	typedef struct {
		logic [1:0]         command;
		logic [15:0]        pixel_index;
		logic [DEPTH_W-1:0] frag_depth;
		logic signed [9:0]  frag_red;
		logic signed [9:0]  frag_green;
		logic signed [9:0]  frag_blue;
		logic signed [9:0]  frag_alpha;
		logic               clear_color_enable;
		logic               clear_depth_enable;
		logic [31:0]        clear_rgba;
		logic [DEPTH_W-1:0] clear_depth_value;
	} rop_req_t;

	typedef struct {
		logic [31:0]        read_rgba;
		logic [DEPTH_W-1:0] read_depth;
		logic               fragment_passed;
	} rop_rsp_t;

	class rop_shadow;
		bit [31:0]        color_px [PIXELS_DEF];
		bit [DEPTH_W-1:0] depth_px [PIXELS_DEF];
		int unsigned      pixels_in_use;
		rop_rsp_t         pending_results [$];
		int               errors;

		function new();
			pixels_in_use = PIX_CFG_RESET;
			errors = 0;
		endfunction

		function int unsigned clamp_unit(logic signed [9:0] v);
			if (v < 0) begin
				return 0;
			end
			if (v > 256) begin
				return 256;
			end
			return v;
		endfunction

		function bit [7:0] blend_byte(bit [7:0] old_b, int unsigned c, int unsigned a);
			bit [31:0] acc;
			acc = old_b * (256 - a) * 256 + c * a * 255;
			return acc[23:16];
		endfunction

		function void accept_request(rop_req_t r);
			rop_rsp_t    res;
			int unsigned a;
			int unsigned n;
			bit [31:0]   old_c;
			bit [31:0]   mixed;
			res.read_rgba = '0;
			res.read_depth = '0;
			res.fragment_passed = 1'b0;
			case (r.command)
				CMD_FRAG: begin
					if (depth_px[r.pixel_index] > r.frag_depth) begin
						a = clamp_unit(r.frag_alpha);
						if (a > 128) begin
							depth_px[r.pixel_index] = r.frag_depth;
						end
						old_c = color_px[r.pixel_index];
						mixed[7:0]   = blend_byte(old_c[7:0], clamp_unit(r.frag_red), a);
						mixed[15:8]  = blend_byte(old_c[15:8], clamp_unit(r.frag_green), a);
						mixed[23:16] = blend_byte(old_c[23:16], clamp_unit(r.frag_blue), a);
						mixed[31:24] = blend_byte(old_c[31:24], a, a);
						color_px[r.pixel_index] = mixed;
						res.fragment_passed = 1'b1;
					end
				end
				CMD_CLEAR: begin
					n = (pixels_in_use > PIXELS_DEF) ? PIXELS_DEF : pixels_in_use;
					for (int unsigned i = 0; i < n; i++) begin
						if (r.clear_color_enable) begin
							color_px[i] = r.clear_rgba;
						end
						if (r.clear_depth_enable) begin
							depth_px[i] = r.clear_depth_value;
						end
					end
				end
				CMD_READ: begin
					res.read_rgba = color_px[r.pixel_index];
					res.read_depth = depth_px[r.pixel_index];
				end
				default: begin
				end
			endcase
			pending_results.push_back(res);
		endfunction

		function void check_result(rop_rsp_t got);
			rop_rsp_t want;
			if (pending_results.size() == 0) begin
				$error("result with no request waiting: rgba %h depth %h passed %b",
					got.read_rgba, got.read_depth, got.fragment_passed);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.read_rgba !== want.read_rgba) begin
				$error("read_rgba: expected %h, actual %h", want.read_rgba, got.read_rgba);
				errors++;
			end
			if (got.read_depth !== want.read_depth) begin
				$error("read_depth: expected %h, actual %h", want.read_depth, got.read_depth);
				errors++;
			end
			if (got.fragment_passed !== want.fragment_passed) begin
				$error("fragment_passed: expected %b, actual %b",
					want.fragment_passed, got.fragment_passed);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	fdbrop_req_if req_ch ();
	fdbrop_rsp_if rsp_ch ();
	fdbrop_cfg_if cfg_ch ();

	fragment_depth_blend_rop_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	rop_shadow   shadow = new();
	int          req_idle_pct = 0;
	int          rsp_stall_pct = 0;
	int unsigned phase_cfg [PHASES] = '{17, 1, 0, 256, 131071, 4096, 1000, 65536};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic signed [9:0] rand_comp();
		int unsigned pick;
		logic signed [9:0] special [8];
		special = '{10'sd0, 10'sd1, 10'sd127, 10'sd128, 10'sd129, 10'sd255, 10'sd256, 10'sd257};
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			return 10'($urandom);
		end else if (pick < 75) begin
			return 10'($urandom_range(0, 256));
		end
		return special[$urandom_range(0, 7)];
	endfunction

	function automatic rop_req_t base_req(logic [1:0] cmd, logic [15:0] px);
		rop_req_t r;
		r.command = cmd;
		r.pixel_index = px;
		r.frag_depth = DEPTH_W'($urandom);
		r.frag_red = 10'($urandom);
		r.frag_green = 10'($urandom);
		r.frag_blue = 10'($urandom);
		r.frag_alpha = 10'($urandom);
		r.clear_color_enable = 1'($urandom);
		r.clear_depth_enable = 1'($urandom);
		r.clear_rgba = $urandom;
		r.clear_depth_value = DEPTH_W'($urandom);
		return r;
	endfunction

	function automatic rop_req_t frag_req(logic [15:0] px, logic [DEPTH_W-1:0] d,
			logic signed [9:0] cr, logic signed [9:0] cg, logic signed [9:0] cb,
			logic signed [9:0] ca);
		rop_req_t r;
		r = base_req(CMD_FRAG, px);
		r.frag_depth = d;
		r.frag_red = cr;
		r.frag_green = cg;
		r.frag_blue = cb;
		r.frag_alpha = ca;
		return r;
	endfunction

	function automatic rop_req_t clear_req(logic ce, logic de, logic [31:0] rgba,
			logic [DEPTH_W-1:0] dv);
		rop_req_t r;
		r = base_req(CMD_CLEAR, 16'($urandom));
		r.clear_color_enable = ce;
		r.clear_depth_enable = de;
		r.clear_rgba = rgba;
		r.clear_depth_value = dv;
		return r;
	endfunction

	function automatic rop_req_t random_request(int unsigned span);
		int unsigned        pick;
		int unsigned        hot;
		logic [15:0]        px;
		logic [DEPTH_W-1:0] d;
		rop_req_t           r;
		hot = (span >= 1 && span < 16) ? span : 16;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			px = 16'($urandom_range(0, hot - 1));
		end else if (pick < 80) begin
			px = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		end else begin
			px = 16'($urandom);
		end
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			r = base_req(CMD_UNUSED, px);
		end else if (pick < 14) begin
			r = base_req(CMD_READ, px);
		end else if (pick < 20 && span <= 4096) begin
			pick = $urandom_range(0, 2);
			if (pick == 0) begin
				d = '1;
			end else if (pick == 1) begin
				d = DEPTH_W'($urandom_range(24'hF00000, 24'hFFFFFF));
			end else begin
				d = DEPTH_W'($urandom);
			end
			r = clear_req($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, $urandom, d);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				d = shadow.depth_px[px] + DEPTH_W'($urandom_range(0, 6)) - DEPTH_W'(3);
			end else if (pick < 60) begin
				d = DEPTH_W'($urandom);
			end else if (pick < 80) begin
				d = shadow.depth_px[px] - DEPTH_W'($urandom_range(0, 4096));
			end else begin
				d = $urandom_range(0, 1) ? '1 : '0;
			end
			r = frag_req(px, d, rand_comp(), rand_comp(), rand_comp(), rand_comp());
		end
		return r;
	endfunction

	task automatic push_request(input rop_req_t r);
		if ($urandom_range(0, 99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < req_idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= r.command;
		req_ch.pixel_index <= r.pixel_index;
		req_ch.frag_depth <= r.frag_depth;
		req_ch.frag_red <= r.frag_red;
		req_ch.frag_green <= r.frag_green;
		req_ch.frag_blue <= r.frag_blue;
		req_ch.frag_alpha <= r.frag_alpha;
		req_ch.clear_color_enable <= r.clear_color_enable;
		req_ch.clear_depth_enable <= r.clear_depth_enable;
		req_ch.clear_rgba <= r.clear_rgba;
		req_ch.clear_depth_value <= r.clear_depth_value;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		shadow.accept_request(r);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (shadow.pending_results.size() != 0);
	endtask

	task automatic write_pixels_in_use(input int unsigned v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.pixels_in_use <= PIX_CFG_W'(v);
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		shadow.pixels_in_use = v;
	endtask

	initial begin
		rop_rsp_t got;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.read_rgba = rsp_ch.read_rgba;
				got.read_depth = rsp_ch.read_depth;
				got.fragment_passed = rsp_ch.fragment_passed;
				shadow.check_result(got);
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("fragment_depth_blend_rop_top_tb: errors");
		$finish;
	end

	initial begin
		req_ch.valid <= 1'b0;
		req_ch.command <= CMD_FRAG;
		req_ch.pixel_index <= '0;
		req_ch.frag_depth <= '0;
		req_ch.frag_red <= '0;
		req_ch.frag_green <= '0;
		req_ch.frag_blue <= '0;
		req_ch.frag_alpha <= '0;
		req_ch.clear_color_enable <= 1'b0;
		req_ch.clear_depth_enable <= 1'b0;
		req_ch.clear_rgba <= '0;
		req_ch.clear_depth_value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.pixels_in_use <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The buffers hold garbage after reset, so the first request fills every pixel.
		push_request(clear_req(1'b1, 1'b1, $urandom, '1));
		drain_results();
		write_pixels_in_use(phase_cfg[0]);

		push_request(frag_req(16'h0000, '0, 10'sd511, 10'sd511, 10'sd511, 10'sd511));
		push_request(frag_req(16'h0000, '0, 10'sd100, 10'sd100, 10'sd100, 10'sd200));
		push_request(frag_req(16'hFFFF, 24'hFFFFFE, -10'sd512, -10'sd512, -10'sd512, 10'sd128));
		push_request(frag_req(16'hFFFF, 24'hFFFFFE, 10'sd300, 10'sd256, 10'sd257, 10'sd129));
		push_request(frag_req(16'hFFFF, 24'hFFFFFF, 10'sd50, 10'sd60, 10'sd70, 10'sd256));
		push_request(frag_req(16'hFFFF, '0, 10'sd100, 10'sd200, 10'sd50, 10'sd0));
		push_request(base_req(CMD_READ, 16'h0000));
		push_request(base_req(CMD_READ, 16'hFFFF));
		push_request(base_req(CMD_UNUSED, 16'($urandom)));
		push_request(clear_req(1'b1, 1'b0, 32'hFFFFFFFF, '0));
		push_request(base_req(CMD_READ, 16'd16));
		push_request(base_req(CMD_READ, 16'd17));
		push_request(clear_req(1'b0, 1'b1, $urandom, '0));
		push_request(frag_req(16'd5, '0, 10'sd256, 10'sd256, 10'sd256, 10'sd256));
		push_request(clear_req(1'b0, 1'b0, $urandom, DEPTH_W'($urandom)));
		push_request(base_req(CMD_READ, 16'd5));
		push_request(clear_req(1'b1, 1'b1, 32'h00000000, '1));
		push_request(frag_req(16'd3, 24'hFFFFFE, 10'sd256, 10'sd256, 10'sd256, 10'sd256));
		push_request(frag_req(16'd3, 24'h000001, 10'sd1, -10'sd1, 10'sd255, 10'sd200));
		push_request(base_req(CMD_READ, 16'd3));

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				drain_results();
				write_pixels_in_use(phase_cfg[p]);
			end
			case (p % 4)
				0: begin
					req_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					req_idle_pct = 85;
					rsp_stall_pct = 0;
				end
				2: begin
					req_idle_pct = 0;
					rsp_stall_pct = 85;
				end
				default: begin
					req_idle_pct = 13;
					rsp_stall_pct = 13;
				end
			endcase
			if (phase_cfg[p] > PIXELS_DEF) begin
				push_request(clear_req(1'b1, 1'b1, $urandom,
					DEPTH_W'($urandom_range(24'hF00000, 24'hFFFFFF))));
			end
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				push_request(random_request(phase_cfg[p]));
			end
		end

		drain_results();
		repeat (16) @(posedge clk);
		if (shadow.errors == 0 && shadow.pending_results.size() == 0) begin
			$display("fragment_depth_blend_rop_top_tb: clean");
		end else begin
			$display("fragment_depth_blend_rop_top_tb: errors");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/fdbrop_pkg.sv
hdl/fdbrop_if.sv
hdl/fdbrop_mix.sv
hdl/fragment_depth_blend_rop_top.sv
hdl/fdbrop_checker.sv
sim/fragment_depth_blend_rop_top_tb.sv
